// ----- hw/rtl/lis_pkg.sv -----
// Shared types, sizes and helpers for the longest-increasing-subsequence block.
// No dependencies; imported by the tail RAM, the search controller and the top level.
package lis_pkg;

  // Table depth and stored value width
  localparam int MAX_LEN     = 1024;
  localparam int VALUE_WIDTH = 32;

  // Count holds 0..MAX_LEN, address holds 0..MAX_LEN-1
  localparam int CNT_W  = $clog2(MAX_LEN + 1);
  localparam int ADDR_W = $clog2(MAX_LEN);

  // Width of the lis_length result field
  localparam int LEN_W = 11;

  typedef logic signed [VALUE_WIDTH-1:0] val_t;
  typedef logic [CNT_W-1:0]              cnt_t;
  typedef logic [ADDR_W-1:0]             addr_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_WRITE
  } state_t;

  // Access request to the tail RAM
  typedef struct packed {
    logic  rd_en;
    logic  wr_en;
    addr_t addr;
    val_t  wdata;
  } ram_req_t;

  // One finished result
  typedef struct packed {
    logic [LEN_W-1:0] lis_length;
    logic             is_last;
    logic             capacity_overflow;
  } res_t;

  // Midpoint of the open search window [lo, hi)
  function automatic cnt_t mid_of(input cnt_t lo, input cnt_t hi);
    cnt_t span;
    span   = hi - lo;
    mid_of = lo + (span >> 1);
  endfunction

endpackage

// ----- hw/rtl/lis_tail_ram.sv -----
// Tail value store: single-port synchronous RAM with registered read.
// Depends on lis_pkg for depth and value width.
module lis_tail_ram (
  input  logic              clk,
  input  lis_pkg::ram_req_t req,
  output lis_pkg::val_t     rdata
);
  import lis_pkg::*;

  val_t mem [MAX_LEN];

  // Write or registered read at the requested entry
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

// ----- hw/rtl/lis_search_ctrl.sv -----
// Binary-search sequencer: takes a transaction, probes the tail RAM once per cycle, then
// overwrites or appends the tail or flags overflow, and hands over the result. Depends on lis_pkg.
module lis_search_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lis_pkg::val_t     key_in,
  input  logic              start_in,
  input  logic              end_in,
  output lis_pkg::ram_req_t ram_req,
  input  lis_pkg::val_t     ram_rdata,
  input  logic              out_free,
  output logic              res_load,
  output lis_pkg::res_t     res
);
  import lis_pkg::*;

  state_t state, state_next;
  cnt_t   lo, lo_next;
  cnt_t   hi, hi_next;
  cnt_t   mid, mid_next;
  cnt_t   count, count_next;
  logic   overflow, overflow_next;
  val_t   key, key_next;
  logic   last, last_next;

  cnt_t   cnt_base;
  cnt_t   lo_n;
  cnt_t   hi_n;
  logic   ge;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      overflow <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      overflow <= overflow_next;
    end
  end

  // Search window and held item
  always_ff @(posedge clk) begin
    lo   <= lo_next;
    hi   <= hi_next;
    mid  <= mid_next;
    key  <= key_next;
    last <= last_next;
  end

  // Next state, RAM requests and result
  always_comb begin
    state_next    = state;
    lo_next       = lo;
    hi_next       = hi;
    mid_next      = mid;
    count_next    = count;
    overflow_next = overflow;
    key_next      = key;
    last_next     = last;
    in_ready      = 1'b0;
    res_load      = 1'b0;
    ram_req       = '0;
    ram_req.wdata = key;
    cnt_base      = start_in ? '0 : count;
    ge            = (ram_rdata >= key);
    lo_n          = ge ? lo : mid + cnt_t'(1);
    hi_n          = ge ? mid : hi;

    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          key_next   = key_in;
          last_next  = end_in;
          count_next = cnt_base;
          if (start_in) begin
            overflow_next = 1'b0;
          end
          lo_next  = '0;
          hi_next  = cnt_base;
          mid_next = mid_of('0, cnt_base);
          if (cnt_base != '0) begin
            ram_req.rd_en = 1'b1;
            ram_req.addr  = mid_next[ADDR_W-1:0];
            state_next    = ST_PROBE;
          end else begin
            state_next = ST_WRITE;
          end
        end
      end

      // Read data of the previous probe is present; narrow and maybe probe again
      ST_PROBE: begin
        lo_next  = lo_n;
        hi_next  = hi_n;
        mid_next = mid_of(lo_n, hi_n);
        if (lo_n < hi_n) begin
          ram_req.rd_en = 1'b1;
          ram_req.addr  = mid_next[ADDR_W-1:0];
        end else begin
          state_next = ST_WRITE;
        end
      end

      // Overwrite, append or flag overflow once the result slot is free
      ST_WRITE: begin
        if (out_free) begin
          if (lo < count) begin
            ram_req.wr_en = 1'b1;
            ram_req.addr  = lo[ADDR_W-1:0];
          end else if (count < cnt_t'(MAX_LEN)) begin
            ram_req.wr_en = 1'b1;
            ram_req.addr  = count[ADDR_W-1:0];
            count_next    = count + cnt_t'(1);
          end else begin
            overflow_next = 1'b1;
          end
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    res.lis_length        = LEN_W'(count_next);
    res.is_last           = last;
    res.capacity_overflow = overflow_next;
  end

endmodule

// ----- hw/rtl/lis_length_tails_search.sv -----
// Top level of the streaming LIS length block: search controller, tail RAM, result register.
// Depends on lis_pkg, lis_search_ctrl and lis_tail_ram.
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------------------------
//   in      | in_valid / in_ready | value, starts_sequence, ends_sequence
//   out     | out_valid/out_ready | lis_length, is_last, capacity_overflow
//
// One transaction at a time: an accept step, one binary-search probe per cycle
// (up to ceil(log2(count+1)) probes, at most 11 for 1024 entries), then a write-back
// step that waits for a free result register. The single RAM port sets the pace.
// Synchronous active-high reset clears count, overflow flag and control; the table
// contents are not cleared and no clearing pass is run. A stalled output holds the
// write-back until the result register is free; a new item is taken while a result waits.
module lis_length_tails_search (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   value,
  input  logic                 starts_sequence,
  input  logic                 ends_sequence,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [lis_pkg::LEN_W-1:0] lis_length,
  output logic                 is_last,
  output logic                 capacity_overflow
);
  import lis_pkg::*;

  ram_req_t ram_req;
  val_t     ram_rdata;
  val_t     key_in;
  logic     out_free;
  logic     res_load;
  res_t     res;
  res_t     res_q;

  // Low VALUE_WIDTH bits, sign-extended
  assign key_in   = val_t'(value);
  assign out_free = !out_valid || out_ready;

  lis_search_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .key_in    (key_in),
    .start_in  (starts_sequence),
    .end_in    (ends_sequence),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .out_free  (out_free),
    .res_load  (res_load),
    .res       (res)
  );

  lis_tail_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_q <= res;
    end
  end

  assign lis_length        = res_q.lis_length;
  assign is_last           = res_q.is_last;
  assign capacity_overflow = res_q.capacity_overflow;

endmodule
